@@ design/rrpf_pkg.sv @@
// ----------------------------------------------------------------------------
// rrpf_pkg
// Shared types, codes and limits of the range rule packet filter.
// ----------------------------------------------------------------------------
`default_nettype none
package rrpf_pkg;

	localparam int RulesDef = 16;
	localparam int SeenDef  = 8;

	// widest history entry address and slot index over the parameter range
	localparam int EntMaxW  = 14;
	localparam int SlotMaxW = 8;

	localparam logic [1:0] FuncAdd   = 2'd0;
	localparam logic [1:0] FuncDel   = 2'd1;
	localparam logic [1:0] FuncCheck = 2'd2;

	localparam logic [2:0] StAdded    = 3'd0;
	localparam logic [2:0] StInvalid  = 3'd1;
	localparam logic [2:0] StDeleted  = 3'd2;
	localparam logic [2:0] StNotFound = 3'd3;
	localparam logic [2:0] StAccepted = 3'd4;
	localparam logic [2:0] StRejected = 3'd5;
	localparam logic [2:0] StFull     = 3'd6;

	typedef struct packed {
		logic [31:0] addr_low;
		logic [31:0] addr_high;
		logic [15:0] port_low;
		logic [15:0] port_high;
	} rule_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
	} seen_t;

	typedef struct packed {
		logic [EntMaxW-1:0]  rd_addr;
		logic                wr_en;
		logic [EntMaxW-1:0]  wr_addr;
		seen_t               wr_data;
		logic                wr_valid;
		logic                clr_en;
		logic [SlotMaxW-1:0] clr_slot;
	} seen_cmd_t;

endpackage
`default_nettype wire

@@ design/range_rule_packet_filter.sv @@
// ----------------------------------------------------------------------------
// range_rule_packet_filter
// Ordered table of address/port range rules with per-rule pair history.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | func addr_low addr_high
//          |           |                      | port_low port_high
//  rsp     | out       | rsp_valid/rsp_stall  | status rule_slot history_full
//
// Sequence: add, invalid and unused operations go straight to the result
// register. Delete scans the rules in order and moves every later rule up
// with all of its history entries. Check scans the rules in order and walks
// the history of each rule whose range holds the pair, through the registered
// read port of the history memory.
// Reset clears the rule count and all history valid flops at once.
// A stalled result holds in the output register; the next item is taken
// while it waits, and the following result waits for the register to free.
//
`default_nettype none
module range_rule_packet_filter #(
	parameter int RULES         = rrpf_pkg::RulesDef,
	parameter int SEEN_PER_RULE = rrpf_pkg::SeenDef
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	output logic        req_stall,
	input  wire  [1:0]  func,
	input  wire  [31:0] addr_low,
	input  wire  [31:0] addr_high,
	input  wire  [15:0] port_low,
	input  wire  [15:0] port_high,
	output logic        rsp_valid,
	input  wire         rsp_stall,
	output logic [2:0]  status,
	output logic [3:0]  rule_slot,
	output logic        history_full
);

	localparam int CW   = $clog2(RULES + 1);
	localparam int RIW  = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int HW   = (SEEN_PER_RULE > 1) ? $clog2(SEEN_PER_RULE) : 1;
	localparam int EW   = rrpf_pkg::EntMaxW;
	localparam int SW   = rrpf_pkg::SlotMaxW;
	localparam logic [HW-1:0] KLast = HW'(SEEN_PER_RULE - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DREQ = 4'd1;
	localparam logic [3:0] S_DCMP = 4'd2;
	localparam logic [3:0] S_MRD  = 4'd3;
	localparam logic [3:0] S_MWR  = 4'd4;
	localparam logic [3:0] S_DFIN = 4'd5;
	localparam logic [3:0] S_CREQ = 4'd6;
	localparam logic [3:0] S_CCMP = 4'd7;
	localparam logic [3:0] S_HREQ = 4'd8;
	localparam logic [3:0] S_HCMP = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]      state_q;
	rrpf_pkg::rule_t key_q;
	logic [CW-1:0]   cnt_q, i_q, j_q;
	logic [HW-1:0]   k_q, free_k_q;
	logic            seen_q, free_ok_q;
	logic [2:0]      res_st_q;
	logic [3:0]      res_slot_q;
	logic            res_hf_q;

	rrpf_pkg::rule_t rmem [RULES];
	rrpf_pkg::rule_t rule_q;
	logic [RIW-1:0]  rd_idx;
	logic            rwr_en;
	logic [RIW-1:0]  rwr_idx;
	rrpf_pkg::rule_t rwr_data;

	rrpf_pkg::seen_cmd_t cmd;
	rrpf_pkg::seen_t     sd_q;
	logic                sv_q;

	rrpf_pkg::rule_t in_rule;
	logic            in_bad, in_take, out_free;
	logic            hit_now, seen_n, free_ok_n;
	logic [HW-1:0]   free_k_n;
	logic            in_range, same_rule;
	logic [CW-1:0]   j_next;

	function automatic logic [EW-1:0] ent(input logic [CW-1:0] r, input logic [HW-1:0] k);
		ent = EW'(r) * EW'(SEEN_PER_RULE) + EW'(k);
	endfunction

	rrpf_seen_store #(
		.RULES         (RULES),
		.SEEN_PER_RULE (SEEN_PER_RULE)
	) u_seen (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_data_q  (sd_q),
		.rd_valid_q (sv_q)
	);

	assign in_rule   = '{addr_low: addr_low, addr_high: addr_high,
	                     port_low: port_low, port_high: port_high};
	assign in_bad    = (addr_low > addr_high) || (port_low > port_high);
	assign req_stall = (state_q != S_IDLE);
	assign in_take   = req_valid && !req_stall;
	assign out_free  = !rsp_valid || !rsp_stall;

	// rule compare on the registered table read
	assign in_range  = (key_q.addr_low >= rule_q.addr_low) &&
	                   (key_q.addr_low <= rule_q.addr_high) &&
	                   (key_q.port_low >= rule_q.port_low) &&
	                   (key_q.port_low <= rule_q.port_high);
	assign same_rule = (key_q == rule_q);

	// history walk: note a hit and the first free entry
	assign hit_now   = sv_q && (sd_q.addr == key_q.addr_low) && (sd_q.port == key_q.port_low);
	assign seen_n    = seen_q || hit_now;
	assign free_ok_n = free_ok_q || !sv_q;
	assign free_k_n  = (!free_ok_q && !sv_q) ? k_q : free_k_q;
	assign j_next    = j_q + CW'(1);

	// read address of the rule table
	always_comb begin
		if (state_q == S_MRD) begin
			rd_idx = j_next[RIW-1:0];
		end else begin
			rd_idx = i_q[RIW-1:0];
		end
	end

	// history store and rule table write controls
	always_comb begin
		cmd          = '0;
		rwr_en       = 1'b0;
		rwr_idx      = cnt_q[RIW-1:0];
		rwr_data     = in_rule;
		cmd.rd_addr  = ent(i_q, k_q);
		unique case (state_q)
			S_IDLE: begin
				if (in_take && func == rrpf_pkg::FuncAdd && !in_bad && cnt_q < CW'(RULES)) begin
					rwr_en       = 1'b1;
					cmd.clr_en   = 1'b1;
					cmd.clr_slot = SW'(cnt_q);
				end
			end
			S_MRD: begin
				cmd.rd_addr = ent(j_next, k_q);
			end
			S_MWR: begin
				rwr_en       = 1'b1;
				rwr_idx      = j_q[RIW-1:0];
				rwr_data     = rule_q;
				cmd.wr_en    = 1'b1;
				cmd.wr_addr  = ent(j_q, k_q);
				cmd.wr_data  = sd_q;
				cmd.wr_valid = sv_q;
			end
			S_DFIN: begin
				cmd.clr_en   = 1'b1;
				cmd.clr_slot = SW'(cnt_q - CW'(1));
			end
			S_HCMP: begin
				if (k_q == KLast && !seen_n && free_ok_n) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_addr  = ent(i_q, free_k_n);
					cmd.wr_data  = '{addr: key_q.addr_low, port: key_q.port_low};
					cmd.wr_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rule_q <= rmem[rd_idx];
		if (rwr_en) begin
			rmem[rwr_idx] <= rwr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			// raise the result when it loads, drop it once taken
			if (state_q == S_FIN && out_free) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						i_q      <= '0;
						res_hf_q <= 1'b0;
						if ((func == rrpf_pkg::FuncAdd || func == rrpf_pkg::FuncDel) && in_bad) begin
							res_st_q   <= rrpf_pkg::StInvalid;
							res_slot_q <= '0;
							state_q    <= S_FIN;
						end else if (func == rrpf_pkg::FuncAdd) begin
							state_q <= S_FIN;
							if (cnt_q >= CW'(RULES)) begin
								res_st_q   <= rrpf_pkg::StFull;
								res_slot_q <= '0;
							end else begin
								cnt_q      <= cnt_q + CW'(1);
								res_st_q   <= rrpf_pkg::StAdded;
								res_slot_q <= 4'(cnt_q);
							end
						end else if (func == rrpf_pkg::FuncDel) begin
							res_slot_q <= '0;
							state_q    <= S_DREQ;
						end else if (func == rrpf_pkg::FuncCheck) begin
							res_slot_q <= '0;
							state_q    <= S_CREQ;
						end else begin
							res_st_q   <= rrpf_pkg::StRejected;
							res_slot_q <= '0;
							state_q    <= S_FIN;
						end
					end
				end
				S_DREQ: begin
					if (i_q >= cnt_q) begin
						res_st_q <= rrpf_pkg::StNotFound;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_DCMP;
					end
				end
				S_DCMP: begin
					if (same_rule) begin
						j_q <= i_q;
						k_q <= '0;
						state_q <= ((i_q + CW'(1)) >= cnt_q) ? S_DFIN : S_MRD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_DREQ;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					// advance one history entry, then the next slot up
					if (k_q == KLast) begin
						k_q     <= '0;
						j_q     <= j_next;
						state_q <= ((j_next + CW'(1)) >= cnt_q) ? S_DFIN : S_MRD;
					end else begin
						k_q     <= k_q + HW'(1);
						state_q <= S_MRD;
					end
				end
				S_DFIN: begin
					cnt_q      <= cnt_q - CW'(1);
					res_st_q   <= rrpf_pkg::StDeleted;
					res_slot_q <= 4'(i_q);
					state_q    <= S_FIN;
				end
				S_CREQ: begin
					if (i_q >= cnt_q) begin
						res_st_q <= rrpf_pkg::StRejected;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_CCMP;
					end
				end
				S_CCMP: begin
					if (in_range) begin
						k_q       <= '0;
						seen_q    <= 1'b0;
						free_ok_q <= 1'b0;
						free_k_q  <= '0;
						state_q   <= S_HREQ;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_CREQ;
					end
				end
				S_HREQ: begin
					state_q <= S_HCMP;
				end
				S_HCMP: begin
					seen_q    <= seen_n;
					free_ok_q <= free_ok_n;
					free_k_q  <= free_k_n;
					if (k_q != KLast) begin
						k_q     <= k_q + HW'(1);
						state_q <= S_HREQ;
					end else if (seen_n) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_CREQ;
					end else begin
						res_st_q   <= rrpf_pkg::StAccepted;
						res_slot_q <= 4'(i_q);
						res_hf_q   <= !free_ok_n;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register frees
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// latch the item and load the result register
	always_ff @(posedge clk) begin
		if (in_take) begin
			key_q <= in_rule;
		end
		if (state_q == S_FIN && out_free) begin
			status       <= res_st_q;
			rule_slot    <= res_slot_q;
			history_full <= res_hf_q;
		end
	end

endmodule
`default_nettype wire

@@ design/rrpf_seen_store.sv @@
// ----------------------------------------------------------------------------
// rrpf_seen_store
// History memory of accepted pairs with one valid flop per entry.
// ----------------------------------------------------------------------------
`default_nettype none
module rrpf_seen_store #(
	parameter int RULES         = rrpf_pkg::RulesDef,
	parameter int SEEN_PER_RULE = rrpf_pkg::SeenDef
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  rrpf_pkg::seen_cmd_t     cmd,
	output rrpf_pkg::seen_t         rd_data_q,
	output logic                    rd_valid_q
);

	localparam int Ents = RULES * SEEN_PER_RULE;
	localparam int EW   = (Ents > 1) ? $clog2(Ents) : 1;
	localparam int RIW  = (RULES > 1) ? $clog2(RULES) : 1;

	rrpf_pkg::seen_t mem [Ents];
	logic [Ents-1:0] valid_q;

	// registered read
	always_ff @(posedge clk) begin
		rd_data_q <= mem[cmd.rd_addr[EW-1:0]];
		if (cmd.wr_en) begin
			mem[cmd.wr_addr[EW-1:0]] <= cmd.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[cmd.rd_addr[EW-1:0]];
			if (cmd.wr_en) begin
				valid_q[cmd.wr_addr[EW-1:0]] <= cmd.wr_valid;
			end
			// drop the whole history of one slot
			if (cmd.clr_en) begin
				for (int k = 0; k < SEEN_PER_RULE; k++) begin
					valid_q[EW'(cmd.clr_slot[RIW-1:0]) * EW'(SEEN_PER_RULE) + EW'(k)] <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ design/rrpf_checker.sv @@
// ----------------------------------------------------------------------------
// rrpf_checker
// Port-level checks of the range rule packet filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rrpf_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       rsp_valid,
	input wire       rsp_stall,
	input wire [2:0] status,
	input wire [3:0] rule_slot,
	input wire       history_full
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= rrpf_pkg::StFull)
		else $error("status out of range");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != rrpf_pkg::StAdded && status != rrpf_pkg::StDeleted &&
		status != rrpf_pkg::StAccepted |-> rule_slot == 4'd0)
		else $error("slot set without a rule");

	a_hf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && history_full |-> status == rrpf_pkg::StAccepted)
		else $error("history flag without accept");

endmodule

bind range_rule_packet_filter rrpf_checker u_rrpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.status       (status),
	.rule_slot    (rule_slot),
	.history_full (history_full)
);
`default_nettype wire

@@ bench/range_rule_packet_filter_test.sv @@
// ----------------------------------------------------------------------------
// range_rule_packet_filter_test
// Drives add, delete, check and unused requests into the rule filter and compares
// every response with a behavioral model of the rule table and pair history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module range_rule_packet_filter_test;

	localparam int NRULE = 16;
	localparam int NSEEN = 8;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] al;
		logic [31:0] ah;
		logic [15:0] pl;
		logic [15:0] ph;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic       hfull;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] func = '0;
	logic [31:0] addr_low = '0, addr_high = '0;
	logic [15:0] port_low = '0, port_high = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [2:0] status;
	logic [3:0] rule_slot;
	logic history_full;

	range_rule_packet_filter dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .addr_low(addr_low), .addr_high(addr_high),
		.port_low(port_low), .port_high(port_high),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .rule_slot(rule_slot), .history_full(history_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the rule table
	int unsigned          tbl_count;
	rrpf_pkg::rule_t      tbl [NRULE];
	logic                 hist_v [NRULE][NSEEN];
	rrpf_pkg::seen_t      hist [NRULE][NSEEN];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   recv_hold = 1'b0;
	int   mismatches = 0;
	int   rsp_seen = 0;
	int   n_added = 0, n_deleted = 0, n_accepted = 0, n_hfull = 0;

	// apply one request to the model, return the expected response
	function automatic rsp_t filter_apply(req_t r);
		rsp_t o;
		bit   hit;
		int   free_at;
		o = '0;
		o.status = rrpf_pkg::StRejected;
		if (r.func == rrpf_pkg::FuncAdd || r.func == rrpf_pkg::FuncDel) begin
			if (r.al > r.ah || r.pl > r.ph) begin
				o.status = rrpf_pkg::StInvalid;
			end else if (r.func == rrpf_pkg::FuncAdd) begin
				if (tbl_count >= NRULE) begin
					o.status = rrpf_pkg::StFull;
				end else begin
					tbl[tbl_count] = '{r.al, r.ah, r.pl, r.ph};
					for (int j = 0; j < NSEEN; j++) hist_v[tbl_count][j] = 1'b0;
					o.status = rrpf_pkg::StAdded;
					o.slot = tbl_count[3:0];
					tbl_count++;
				end
			end else begin
				o.status = rrpf_pkg::StNotFound;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl[i] == rrpf_pkg::rule_t'{r.al, r.ah, r.pl, r.ph}) begin
						for (int k = i; k + 1 < tbl_count; k++) begin
							tbl[k] = tbl[k+1];
							hist_v[k] = hist_v[k+1];
							hist[k] = hist[k+1];
						end
						tbl_count--;
						for (int j = 0; j < NSEEN; j++) hist_v[tbl_count][j] = 1'b0;
						o.status = rrpf_pkg::StDeleted;
						o.slot = i[3:0];
						break;
					end
				end
			end
		end else if (r.func == rrpf_pkg::FuncCheck) begin
			for (int i = 0; i < tbl_count; i++) begin
				if (r.al < tbl[i].addr_low || r.al > tbl[i].addr_high ||
				    r.pl < tbl[i].port_low || r.pl > tbl[i].port_high)
					continue;
				hit = 1'b0;
				free_at = -1;
				for (int j = 0; j < NSEEN; j++) begin
					if (hist_v[i][j]) begin
						if (hist[i][j].addr == r.al && hist[i][j].port == r.pl) hit = 1'b1;
					end else if (free_at < 0) begin
						free_at = j;
					end
				end
				if (hit) continue;
				o.status = rrpf_pkg::StAccepted;
				o.slot = i[3:0];
				if (free_at < 0) begin
					o.hfull = 1'b1;
				end else begin
					hist_v[i][free_at] = 1'b1;
					hist[i][free_at] = '{r.al, r.pl};
				end
				break;
			end
		end
		return o;
	endfunction

	// driver: advance on acceptance, change inputs at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					req_t r;
					r = pending_reqs.pop_front();
					expected_rsps.push_back(filter_apply(r));
					req_valid <= 1'b1;
					func <= r.func;
					addr_low <= r.al;
					addr_high <= r.ah;
					port_low <= r.pl;
					port_high <= r.ph;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: compare each accepted response with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_t got, want;
			got = '{status, rule_slot, history_full};
			rsp_seen++;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response status=%0d slot=%0d hfull=%0d",
						status, rule_slot, history_full);
			end else begin
				want = expected_rsps.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: want st=%0d slot=%0d hf=%0d, got st=%0d slot=%0d hf=%0d",
							rsp_seen, want.status, want.slot, want.hfull,
							got.status, got.slot, got.hfull);
				end
				if (want.status == rrpf_pkg::StAdded) n_added++;
				if (want.status == rrpf_pkg::StDeleted) n_deleted++;
				if (want.status == rrpf_pkg::StAccepted) n_accepted++;
				if (want.hfull) n_hfull++;
			end
		end
	end

	function automatic req_t mk(logic [1:0] f, logic [31:0] al, logic [31:0] ah,
			logic [15:0] pl, logic [15:0] ph);
		mk = '{f, al, ah, pl, ph};
	endfunction

	// a rule somewhere in a small window so checks hit often
	function automatic req_t rand_rule(logic [1:0] f);
		logic [31:0] a;
		logic [15:0] p;
		a = ($urandom_range(3) == 0) ? $urandom : 32'hA000_0000 + $urandom_range(40);
		p = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(1000 + $urandom_range(20));
		rand_rule = mk(f, a, a + $urandom_range(12), p, p + 16'($urandom_range(6)));
		if (a > 32'hFFFF_FFF0) rand_rule.ah = 32'hFFFF_FFFF;
		if (p > 16'hFFF0) rand_rule.ph = 16'hFFFF;
	endfunction

	function automatic req_t rand_check();
		rand_check = mk(rrpf_pkg::FuncCheck, 32'hA000_0000 + $urandom_range(55), $urandom,
			16'(1000 + $urandom_range(28)), 16'($urandom));
		if ($urandom_range(7) == 0) begin
			rand_check.al = $urandom;
			rand_check.pl = 16'($urandom);
		end
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		req_t added [$];
		req_t r;
		int   k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 25) begin
				r = rand_rule(rrpf_pkg::FuncAdd);
				added.push_back(r);
			end else if (k < 37 && added.size() > 0) begin
				int idx;
				idx = $urandom_range(added.size() - 1);
				r = added[idx];
				r.func = rrpf_pkg::FuncDel;
				added.delete(idx);
			end else if (k < 42) begin
				// noise: random fields, any operation, often malformed
				r = mk(2'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
			end else if (k < 45) begin
				r = rand_rule(rrpf_pkg::FuncDel);
			end else begin
				r = rand_check();
			end
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: extremes, each operation, invalid, duplicate, unused op
		pending_reqs.push_back(mk(rrpf_pkg::FuncCheck, 0, 0, 0, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncDel, 0, 0, 0, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncAdd, 5, 4, 0, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncAdd, 0, 0, 9, 8));
		pending_reqs.push_back(mk(rrpf_pkg::FuncDel, 32'hFFFF_FFFF, 0, 0, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncAdd, 0, 32'hFFFF_FFFF, 0, 16'hFFFF));
		pending_reqs.push_back(mk(rrpf_pkg::FuncAdd, 0, 32'hFFFF_FFFF, 0, 16'hFFFF));
		pending_reqs.push_back(mk(rrpf_pkg::FuncAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF));
		pending_reqs.push_back(mk(2'd3, 32'hFFFF_FFFF, 0, 16'hFFFF, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncCheck, 32'hFFFF_FFFF, 0, 16'hFFFF, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncCheck, 32'hFFFF_FFFF, 0, 16'hFFFF, 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncCheck, 32'hFFFF_FFFF, 0, 16'hFFFF, 0));
		// fill one rule's history, then overflow it twice
		for (int i = 0; i < 10; i++)
			pending_reqs.push_back(mk(rrpf_pkg::FuncCheck, 32'h1234_0000, 0, 16'(i % 9), 0));
		pending_reqs.push_back(mk(rrpf_pkg::FuncDel, 0, 32'hFFFF_FFFF, 0, 16'hFFFF));
		pending_reqs.push_back(mk(rrpf_pkg::FuncCheck, 32'h1234_0000, 0, 0, 0));
		drain();
		// fill the table; the last three adds get table full
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(mk(rrpf_pkg::FuncAdd, i, i + 100, 16'(i), 16'(i)));
		drain();
		// delete the added rules from the last one back, then the all-ones rule
		for (int i = 16; i >= 0; i--)
			pending_reqs.push_back(mk(rrpf_pkg::FuncDel, i, i + 100, 16'(i), 16'(i)));
		pending_reqs.push_back(mk(rrpf_pkg::FuncDel, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF));
		drain();

		send_idle_pct = 17; recv_idle_pct = 50;
		random_phase(230);
		// hold the receiver long enough that the block backs up into its input
		fork
			begin
				int cnt;
				cnt = 0;
				recv_hold = 1'b1;
				while (cnt < 400) begin
					@(posedge clk);
					cnt++;
				end
				recv_hold = 1'b0;
			end
		join_none
		drain();

		send_idle_pct = 50; recv_idle_pct = 17;
		random_phase(230);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(240);
		drain();
		repeat (300) @(posedge clk);

		$display("covered %0d responses: %0d adds, %0d deletes, %0d accepts (%0d history full)",
			rsp_seen, n_added, n_deleted, n_accepted, n_hfull);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("range_rule_packet_filter_test OK");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
			$display("range_rule_packet_filter_test NOT OK");
		end
		$finish;
	end

	// watchdog: ends a run that hangs under heavy receiver stall
	initial begin
		#20_000_000;
		$display("timeout");
		$display("range_rule_packet_filter_test NOT OK");
		$finish;
	end

endmodule
